>>> rtl/core/assert_macros.svh
// Assertion helpers. Clock clk, active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HCA_ASSERT_NOW(lbl, ante, cons)
`define HCA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/hca_pkg.sv
`default_nettype none
package hca_pkg;

    localparam int HCA_FRAC_BITS = 16;
    localparam int HCA_DVS_W     = 12;
    localparam int HCA_OFF_RED   = 2;
    localparam int HCA_OFF_GREEN = 0;
    localparam int HCA_OFF_BLUE  = -2;

    typedef enum logic [1:0]
    {
        REG_HUE_SHIFT  = 2'd0,
        REG_SAT_FIX    = 2'd1,
        REG_LIGHT_FIX  = 2'd2
    } hca_reg_idx_t;

    // k = 2^15 - |fix|, pos set for a positive fix
    typedef struct packed
    {
        logic [15:0] hue_shift;
        logic [16:0] sat_k;
        logic        sat_pos;
        logic [16:0] light_k;
        logic        light_pos;
    } hca_cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/hca_cfg.sv
`default_nettype none
module hca_cfg
    import hca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output hca_cfg_t         cfg
);

    logic [15:0] hue_reg;
    logic [16:0] sat_reg;
    logic [16:0] light_reg;
    hca_reg_idx_t idx;
    logic         wr;

    function automatic logic [16:0] clamp_fix(input logic [16:0] v);
        logic signed [16:0] s;
        s = signed'(v);
        if (s < -17'sd32768)
            return 17'h18000;
        else if (s > 17'sd32768)
            return 17'h08000;
        else
            return v;
    endfunction

    function automatic logic [16:0] fix_k(input logic [16:0] f);
        logic [16:0] k;
        if (f[16])
            k = 17'd32768 + f;
        else
            k = 17'd32768 - f;
        return k;
    endfunction

    assign idx    = hca_reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg   <= '0;
            sat_reg   <= '0;
            light_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_HUE_SHIFT: hue_reg   <= pwdata[15:0];
                REG_SAT_FIX:   sat_reg   <= clamp_fix(pwdata[16:0]);
                REG_LIGHT_FIX: light_reg <= clamp_fix(pwdata[16:0]);
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HUE_SHIFT: prdata = {{16{hue_reg[15]}}, hue_reg};
            REG_SAT_FIX:   prdata = {{15{sat_reg[16]}}, sat_reg};
            REG_LIGHT_FIX: prdata = {{15{light_reg[16]}}, light_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.hue_shift = hue_reg;
        cfg.sat_k     = fix_k(sat_reg);
        cfg.sat_pos   = !sat_reg[16] && (sat_reg != '0);
        cfg.light_k   = fix_k(light_reg);
        cfg.light_pos = !light_reg[16] && (light_reg != '0);
    end

endmodule
`default_nettype wire

>>> rtl/core/hca_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage. Quotient must fit in QW bits.
module hca_div
    import hca_pkg::*;
#(
    parameter int NW = 28,
    parameter int DW = 12,
    parameter int QW = 17
)
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] dvs,
    output logic [QW-1:0]      quo
);

    localparam int RW = DW + QW;

    logic [RW-1:0] rem_reg [QW];
    logic [DW-1:0] dvs_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [DW-1:0] dvs_in;
        logic [QW-1:0] quo_in;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = RW'(num);
            assign dvs_in = dvs;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = RW'(dvs_in) << (QW - 1 - k);
        assign ge    = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (rem_in - trial) : rem_in;
                dvs_reg[k] <= dvs_in;
                quo_reg[k] <= quo_in | (QW'(ge) << (QW - 1 - k));
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule
`default_nettype wire

>>> rtl/core/hca_chan.sv
`default_nettype none
// One output channel: hue sector select, interpolation, byte rounding.
module hca_chan
    import hca_pkg::*;
#(
    parameter int Q   = 16,
    parameter int OFF = 0
)
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [Q-1:0]        hue,
    input  wire logic signed [Q+2:0] v1,
    input  wire logic signed [Q+2:0] v2,
    output logic [7:0]               chan
);

    localparam int TW   = Q + 5;
    localparam int NUMW = 2 * Q + 6;
    localparam int PW   = NUMW + 9;
    localparam logic signed [TW-1:0] ONE  = TW'(64'd1 << Q);
    localparam logic signed [TW-1:0] SIX  = TW'(64'd6 << Q);
    localparam logic signed [TW-1:0] OFFV = TW'(OFF * (2 ** Q));

    logic signed [TW-1:0]   t;
    logic signed [TW-1:0]   t4;
    logic signed [Q+2:0]    base;
    logic [Q:0]             frac;
    logic signed [Q+2:0]    base_reg;
    logic signed [Q+3:0]    diff_reg;
    logic [Q:0]             frac_reg;
    logic signed [NUMW-1:0] num;
    logic signed [NUMW-1:0] num_reg;
    logic [PW-1:0]          prod;
    logic [PW-2*Q-1:0]      byte_w;

    always_comb
    begin
        t = signed'((TW'(hue) << 2) + (TW'(hue) << 1)) + OFFV;
        if (t < 0)
            t = t + SIX;
        if (t >= SIX)
            t = t - SIX;
        t4 = (ONE <<< 2) - t;
        if (t < ONE)
        begin
            base = v1;
            frac = t[Q:0];
        end
        else if (t < 3 * ONE)
        begin
            base = v2;
            frac = '0;
        end
        else if (t < 4 * ONE)
        begin
            base = v1;
            frac = t4[Q:0];
        end
        else
        begin
            base = v1;
            frac = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base;
            diff_reg <= (Q+4)'(v2) - (Q+4)'(v1);
            frac_reg <= frac;
        end
    end

    assign num = (NUMW'(base_reg) <<< Q) + NUMW'(diff_reg * signed'({1'b0, frac_reg}));

    always_ff @(posedge clk)
    begin
        if (en)
            num_reg <= num;
    end

    always_comb
    begin
        if (num_reg < 0)
            prod = '0;
        else
            prod = (PW'(unsigned'(num_reg)) << 8) - PW'(unsigned'(num_reg))
                 + (PW'(1) << (2 * Q - 1));
        byte_w = prod[PW-1:2*Q];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            chan <= (byte_w > (PW-2*Q)'(255)) ? 8'd255 : byte_w[7:0];
    end

endmodule
`default_nettype wire

>>> rtl/core/hsl_color_adjust_unit.sv
`default_nettype none
// Channel  | Kind          | Payload
// s_axis   | stream in     | tdata {blue, green, red}, tlast frame end
// m_axis   | stream out    | tdata {blue, green, red}, tlast frame end
// apb      | config        | hue_shift @0x0, saturation_fix @0x4, lightness_fix @0x8
//
// One pixel per cycle. FRAC_BITS + 10 register stages: one input stage,
// FRAC_BITS + 1 divider stages (one quotient bit each; lightness uses a
// reciprocal multiply and a matching delay line), five adjust stages, three
// channel stages. The whole pipeline, bubbles included, holds while an output
// item waits untaken. Reset clears the valid chain and the config registers.
`include "assert_macros.svh"
module hsl_color_adjust_unit
    import hca_pkg::*;
#(
    parameter int FRAC_BITS = HCA_FRAC_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // red_out, green_out, blue_out
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int Q   = FRAC_BITS;
    localparam int QW  = Q + 1;
    localparam int NW  = Q + 12;
    localparam int DW  = HCA_DVS_W;
    localparam int LAT = Q + 10;
    localparam int SW  = Q + 17;
    localparam logic [QW-1:0] ONE_U = QW'(64'd1 << Q);
    localparam logic signed [Q+2:0] ONE_S = (Q+3)'(64'd1 << Q);
    // ceil(2^(Q+20) / 1020), exact for numerators below 2^(Q+10)
    localparam logic [Q+10:0] L_RECIP = (Q+11)'(((64'd1 << (Q + 20)) + 64'd1019) / 64'd1020);

    hca_cfg_t cfg;
    logic     en;

    logic valid_pipe_reg [LAT];
    logic last_pipe_reg  [LAT];
    logic grey_pipe_reg  [QW+1];

    // input stage
    logic [7:0] r, g, b, mx, mn, d, den;
    logic [8:0] sum;
    logic signed [11:0] n;
    logic [Q+9:0]  num_l_reg;
    logic [NW-1:0] num_s_reg, num_h_reg;
    logic [DW-1:0] dvs_s_reg, dvs_h_reg;
    logic [QW-1:0] quo_l, quo_s, quo_h;
    logic [2*Q+20:0] l_recip_prod;
    logic [QW-1:0] l_div_pipe_reg [QW];

    // adjust stages
    logic [SW-1:0]          shift_wide;
    logic signed [Q+1:0]    shift;
    logic [Q-1:0]           h0;
    logic signed [Q+2:0]    hs;
    logic [QW-1:0]          s0;
    logic [Q-1:0]           h_p1_reg, h_p2_reg, h_p3_reg, h_p4_reg, h_p5_reg;
    logic [QW-1:0]          s_op_reg, l_op_reg;
    logic [QW+15:0]         s_prod_reg, l_prod_reg;
    logic [QW+15:0]         s_rnd, l_rnd;
    logic [QW-1:0]          s_p3_reg, l_p3_reg, s_p4_reg, l_p4_reg;
    logic [2*QW-1:0]        ls_prod_reg;
    logic [2*QW-1:0]        ls_rnd;
    logic signed [Q+2:0]    ls, l_s, s_s, v2, v1;
    logic signed [Q+2:0]    v1_reg, v2_reg;
    logic [7:0]             red_o, green_o, blue_o;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    hca_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb
    begin
        r  = s_axis_tdata[7:0];
        g  = s_axis_tdata[15:8];
        b  = s_axis_tdata[23:16];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d   = mx - mn;
        sum = 9'(mx) + 9'(mn);
        den = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
        if (r == mx)
            n = signed'(12'(g)) - signed'(12'(b));
        else if (g == mx)
            n = signed'(12'(d) << 1) + signed'(12'(b)) - signed'(12'(r));
        else
            n = signed'(12'(d) << 2) + signed'(12'(r)) - signed'(12'(g));
        if (n < 0)
            n = n + signed'(12'(d) * 12'd6);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_l_reg <= ((Q+10)'(sum) << (Q + 1)) + (Q+10)'(510);
            num_s_reg <= (NW'(d) << (Q + 1)) + NW'(den);
            dvs_s_reg <= DW'(den) << 1;
            num_h_reg <= (NW'(unsigned'(n)) << (Q + 1)) + NW'(d) * NW'(6);
            dvs_h_reg <= DW'(d) * DW'(12);
        end
    end

    // lightness: divide by 1020 through a reciprocal, then delay to match
    assign l_recip_prod = (2*Q+21)'(num_l_reg) * (2*Q+21)'(L_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_div_pipe_reg[0] <= l_recip_prod[2*Q+20:Q+20];
            for (int i = 1; i < QW; i++)
                l_div_pipe_reg[i] <= l_div_pipe_reg[i-1];
        end
    end

    assign quo_l = l_div_pipe_reg[QW-1];

    hca_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_s
    (
        .clk (clk),
        .en  (en),
        .num (num_s_reg),
        .dvs (dvs_s_reg),
        .quo (quo_s)
    );

    hca_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_h
    (
        .clk (clk),
        .en  (en),
        .num (num_h_reg),
        .dvs (dvs_h_reg),
        .quo (quo_h)
    );

    // hue shift in Q.q, rounded from Q1.15
    always_comb
    begin
        shift_wide = (SW'({~cfg.hue_shift[15], cfg.hue_shift[14:0]}) << Q) + SW'(16384);
        shift      = signed'(shift_wide[Q+16:15]) - signed'((Q+2)'(64'd1 << Q));
    end

    always_comb
    begin
        h0 = (grey_pipe_reg[QW] || quo_h[Q]) ? '0 : quo_h[Q-1:0];
        hs = signed'((Q+3)'(h0)) + (Q+3)'(shift);
        if (hs >= ONE_S)
            hs = hs - ONE_S;
        else if (hs < 0)
            hs = hs + ONE_S;
        s0 = grey_pipe_reg[QW] ? '0 : quo_s;
    end

    always_comb
    begin
        s_rnd  = s_prod_reg + (QW+16)'(16384);
        l_rnd  = l_prod_reg + (QW+16)'(16384);
        ls_rnd = ls_prod_reg + (2*QW)'(64'd1 << (Q - 1));
        ls     = signed'((Q+3)'(ls_rnd[2*QW-1:Q]));
        l_s    = signed'((Q+3)'(l_p4_reg));
        s_s    = signed'((Q+3)'(s_p4_reg));
        if (l_p4_reg < (ONE_U >> 1))
            v2 = l_s + ls;
        else
            v2 = l_s + s_s - ls;
        v1 = (l_s <<< 1) - v2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_p1_reg    <= hs[Q-1:0];
            s_op_reg    <= cfg.sat_pos ? (ONE_U - s0) : s0;
            l_op_reg    <= cfg.light_pos ? (ONE_U - quo_l) : quo_l;

            h_p2_reg    <= h_p1_reg;
            s_prod_reg  <= (QW+16)'(s_op_reg) * (QW+16)'(cfg.sat_k);
            l_prod_reg  <= (QW+16)'(l_op_reg) * (QW+16)'(cfg.light_k);

            h_p3_reg    <= h_p2_reg;
            s_p3_reg    <= cfg.sat_pos ? (ONE_U - s_rnd[QW+14:15]) : s_rnd[QW+14:15];
            l_p3_reg    <= cfg.light_pos ? (ONE_U - l_rnd[QW+14:15]) : l_rnd[QW+14:15];

            h_p4_reg    <= h_p3_reg;
            s_p4_reg    <= s_p3_reg;
            l_p4_reg    <= l_p3_reg;
            ls_prod_reg <= (2*QW)'(l_p3_reg) * (2*QW)'(s_p3_reg);

            h_p5_reg    <= h_p4_reg;
            v1_reg      <= v1;
            v2_reg      <= v2;
        end
    end

    hca_chan #(.Q(Q), .OFF(HCA_OFF_RED)) u_chan_r
    (
        .clk  (clk),
        .en   (en),
        .hue  (h_p5_reg),
        .v1   (v1_reg),
        .v2   (v2_reg),
        .chan (red_o)
    );

    hca_chan #(.Q(Q), .OFF(HCA_OFF_GREEN)) u_chan_g
    (
        .clk  (clk),
        .en   (en),
        .hue  (h_p5_reg),
        .v1   (v1_reg),
        .v2   (v2_reg),
        .chan (green_o)
    );

    hca_chan #(.Q(Q), .OFF(HCA_OFF_BLUE)) u_chan_b
    (
        .clk  (clk),
        .en   (en),
        .hue  (h_p5_reg),
        .v1   (v1_reg),
        .v2   (v2_reg),
        .chan (blue_o)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                valid_pipe_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_pipe_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++)
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_pipe_reg[0] <= s_axis_tlast;
            for (int i = 1; i < LAT; i++)
                last_pipe_reg[i] <= last_pipe_reg[i-1];
            grey_pipe_reg[0] <= (d == 8'd0);
            for (int i = 1; i <= QW; i++)
                grey_pipe_reg[i] <= grey_pipe_reg[i-1];
        end
    end

    assign m_axis_tvalid = valid_pipe_reg[LAT-1];
    assign m_axis_tlast  = last_pipe_reg[LAT-1];
    assign m_axis_tdata  = {blue_o, green_o, red_o};

    `HCA_ASSERT_NEXT(a_pipe_fill, en && valid_pipe_reg[LAT-2], m_axis_tvalid)
    `HCA_ASSERT_NEXT(a_pipe_hold, !en, valid_pipe_reg[0] == $past(valid_pipe_reg[0]))

endmodule
`default_nettype wire

>>> tb/hsl_adjust_checker.sv
module hsl_adjust_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [23:0] in_data,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] out_data,
    input  logic        out_last,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          errors,
    output int          pending
);
    import hca_pkg::*;

    localparam int FB = HCA_FRAC_BITS;
    localparam longint ONE = longint'(1) << FB;
    localparam longint UNIT = 32768;

    typedef struct packed
    {
        logic       frame_end;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    longint hue_shift_q15;
    longint sat_fix_q15;
    longint light_fix_q15;
    pixel_t expected_pixels[$];

    function automatic longint clamp_fix(logic [16:0] v);
        longint x;
        x = longint'($signed(v));
        if (x < -UNIT)
            x = -UNIT;
        if (x > UNIT)
            x = UNIT;
        return x;
    endfunction

    function automatic longint adjust(longint x, longint f);
        if (f < 0)
            return (x * (UNIT + f) + 16384) >>> 15;
        if (f > 0)
            return ONE - (((ONE - x) * (UNIT - f) + 16384) >>> 15);
        return x;
    endfunction

    function automatic logic [7:0] hue_to_channel(longint t, longint v1, longint v2);
        longint num;
        longint c;
        if (t < 0)
            t += 6 * ONE;
        if (t >= 6 * ONE)
            t -= 6 * ONE;
        if (t < ONE)
            num = v1 * ONE + (v2 - v1) * t;
        else if (t < 3 * ONE)
            num = v2 * ONE;
        else if (t < 4 * ONE)
            num = v1 * ONE + (v2 - v1) * (4 * ONE - t);
        else
            num = v1 * ONE;
        if (num < 0)
            num = 0;
        c = (num * 255 + (longint'(1) << (2 * FB - 1))) >>> (2 * FB);
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t p);
        longint r, g, b, mx, mn, d, sum, h, s, l, den, n, ls, v1, v2, h6;
        pixel_t q;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        h = 0;
        s = 0;
        l = (2 * sum * ONE + 510) / 1020;
        if (d != 0)
        begin
            den = (sum < 255) ? sum : 510 - sum;
            s = (2 * d * ONE + den) / (2 * den);
            if (r == mx)
                n = g - b;
            else if (g == mx)
                n = 2 * d + b - r;
            else
                n = 4 * d + r - g;
            if (n < 0)
                n += 6 * d;
            h = (2 * n * ONE + 6 * d) / (12 * d);
            if (h >= ONE)
                h -= ONE;
        end
        h += (((hue_shift_q15 + UNIT) * ONE + 16384) >>> 15) - ONE;
        if (h >= ONE) h -= ONE;
        if (h < 0) h += ONE;
        s = adjust(s, sat_fix_q15);
        l = adjust(l, light_fix_q15);
        ls = (l * s + (ONE >>> 1)) >>> FB;
        v2 = (l < ONE / 2) ? l + ls : l + s - ls;
        v1 = 2 * l - v2;
        h6 = 6 * h;
        q.red = hue_to_channel(h6 + 2 * ONE, v1, v2);
        q.green = hue_to_channel(h6, v1, v2);
        q.blue = hue_to_channel(h6 - 2 * ONE, v1, v2);
        q.frame_end = p.frame_end;
        return q;
    endfunction

    assign pending = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        pixel_t got;
        if (!rst_n)
        begin
            hue_shift_q15 <= 0;
            sat_fix_q15 <= 0;
            light_fix_q15 <= 0;
            errors <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_addr[3:2])
                    REG_HUE_SHIFT: hue_shift_q15 <= longint'($signed(cfg_wdata[15:0]));
                    REG_SAT_FIX:   sat_fix_q15 <= clamp_fix(cfg_wdata[16:0]);
                    REG_LIGHT_FIX: light_fix_q15 <= clamp_fix(cfg_wdata[16:0]);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(adjust_pixel({in_last, in_data}));
            if (out_valid && out_ready)
            begin
                got = {out_last, out_data};
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected output item %h", got);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (e != got)
                        errors <= errors + 1;
                    if (e.red != got.red)
                        $error("red_out expected %0d got %0d", e.red, got.red);
                    if (e.green != got.green)
                        $error("green_out expected %0d got %0d", e.green, got.green);
                    if (e.blue != got.blue)
                        $error("blue_out expected %0d got %0d", e.blue, got.blue);
                    if (e.frame_end != got.frame_end)
                        $error("frame_end_out expected %0d got %0d",
                            e.frame_end, got.frame_end);
                end
            end
        end
    end
endmodule

>>> tb/testbench.sv
module testbench;
    import hca_pkg::*;

    localparam int LATENCY = HCA_FRAC_BITS + 10;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          hold_off = 0;

    always #1 clk = ~clk;

    hsl_color_adjust_unit DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hsl_adjust_checker checker_inst
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .in_last(s_axis_tlast),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast),
        .cfg_write(psel && penable && pwrite && pready),
        .cfg_addr(paddr), .cfg_wdata(pwdata),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        int gap;
        if (!rst_n || hold_off)
            m_axis_tready <= 0;
        else if (m_axis_tready && !m_axis_tvalid)
            m_axis_tready <= 1;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (m_axis_tready && gap != 0)
            begin
                m_axis_tready <= 0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    task automatic reg_write(hca_reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // valid stays high after an accepted item; drain or a later call with a gap drops it
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
        logic last, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {b, g, r};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_pixels(int count, bit burst);
        logic [7:0] r, g, b;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom;
            g = $urandom;
            b = $urandom;
            case ($urandom_range(0, 5))
                0: begin g = r; b = r; end
                1: g = r;
                2: b = g;
                default: ;
            endcase
            send_pixel(r, g, b, $urandom_range(0, 15) == 0, burst);
        end
    endtask

    logic [31:0] hue_set[6] = '{32'h0, 32'h7fff, 32'h8000, 32'h2aab, 32'hc000, 32'h1234};
    logic [31:0] fix_set[7] = '{32'h0, 32'h8000, 32'h18000, 32'h10000, 32'h0ffff,
        32'h04000, 32'h1c000};

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1;
        // directed: extremes, greys, primaries, max-channel cases, hue near one
        send_pixel(0, 0, 0, 0, 0);
        send_pixel(255, 255, 255, 1, 0);
        send_pixel(128, 128, 128, 0, 0);
        send_pixel(255, 0, 0, 0, 0);
        send_pixel(0, 255, 0, 0, 0);
        send_pixel(0, 0, 255, 0, 0);
        send_pixel(255, 255, 0, 0, 0);
        send_pixel(0, 255, 255, 0, 0);
        send_pixel(255, 0, 255, 0, 0);
        send_pixel(255, 0, 1, 0, 0);
        send_pixel(200, 10, 11, 0, 0);
        send_pixel(1, 0, 0, 1, 0);
        send_pixel(254, 255, 255, 0, 0);
        send_pixel(127, 128, 127, 0, 0);
        send_pixel(170, 85, 85, 0, 0);
        send_pixel(85, 170, 255, 1, 0);
        drain();
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 6)
            begin
                reg_write(REG_HUE_SHIFT, hue_set[phase]);
                reg_write(REG_SAT_FIX, fix_set[phase]);
                reg_write(REG_LIGHT_FIX, fix_set[(phase + 3) % 7]);
            end
            else
            begin
                reg_write(REG_HUE_SHIFT, $urandom);
                reg_write(REG_SAT_FIX, $urandom);
                reg_write(REG_LIGHT_FIX, $urandom);
            end
            if (phase == 3)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                    random_pixels(60, 1);
                join
            end
            else
                random_pixels(155, phase % 4 == 1);
            drain();
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
